@@ rtl/rvdec_pkg.sv @@
// Decoder package: opcode, funct and operation codes and the result record.
// Holds the single-pass decode function used by the RV32 instruction decoder.
`timescale 1ns / 1ps

package rvdec_pkg;

    localparam int unsigned OpW  = 7;
    localparam int unsigned FmtW = 3;
    localparam int unsigned RegW = 5;
    localparam int unsigned XLen = 32;

    // Major opcodes
    localparam logic [6:0] OPC_LOAD     = 7'h03;
    localparam logic [6:0] OPC_STORE    = 7'h23;
    localparam logic [6:0] OPC_BRANCH   = 7'h63;
    localparam logic [6:0] OPC_OPIMM    = 7'h13;
    localparam logic [6:0] OPC_OP       = 7'h33;
    localparam logic [6:0] OPC_AMO      = 7'h2F;
    localparam logic [6:0] OPC_SYSTEM   = 7'h73;
    localparam logic [6:0] OPC_LUI      = 7'h37;
    localparam logic [6:0] OPC_AUIPC    = 7'h17;
    localparam logic [6:0] OPC_JAL      = 7'h6F;
    localparam logic [6:0] OPC_JALR     = 7'h67;
    localparam logic [6:0] OPC_MISC_MEM = 7'h0F;
    localparam logic [6:0] OPC_VLOAD    = 7'h07;
    localparam logic [6:0] OPC_VSTORE   = 7'h27;
    localparam logic [6:0] OPC_VECTOR   = 7'h57;

    // Formats
    localparam logic [FmtW-1:0] FMT_R = 3'd0;
    localparam logic [FmtW-1:0] FMT_I = 3'd1;
    localparam logic [FmtW-1:0] FMT_S = 3'd2;
    localparam logic [FmtW-1:0] FMT_B = 3'd3;
    localparam logic [FmtW-1:0] FMT_U = 3'd4;
    localparam logic [FmtW-1:0] FMT_J = 3'd5;

    // funct7 values
    localparam logic [6:0] F7_BASE = 7'b0000000;
    localparam logic [6:0] F7_ALT  = 7'b0100000;
    localparam logic [6:0] F7_MUL  = 7'b0000001;

    // funct3 values
    localparam logic [2:0] F3_0 = 3'd0;
    localparam logic [2:0] F3_1 = 3'd1;
    localparam logic [2:0] F3_2 = 3'd2;
    localparam logic [2:0] F3_3 = 3'd3;
    localparam logic [2:0] F3_4 = 3'd4;
    localparam logic [2:0] F3_5 = 3'd5;
    localparam logic [2:0] F3_6 = 3'd6;
    localparam logic [2:0] F3_7 = 3'd7;

    // Vector funct3 categories
    localparam logic [2:0] VF3_OPIVV = 3'd0;
    localparam logic [2:0] VF3_OPMVV = 3'd2;
    localparam logic [2:0] VF3_OPIVX = 3'd4;
    localparam logic [2:0] VF3_CFG   = 3'd7;
    localparam logic [2:0] VF3_EW32  = 3'd6;

    // AMO funct5
    localparam logic [4:0] AMO_LR   = 5'h02;
    localparam logic [4:0] AMO_SC   = 5'h03;
    localparam logic [4:0] AMO_SWAP = 5'h01;
    localparam logic [4:0] AMO_ADD  = 5'h00;
    localparam logic [4:0] AMO_XOR  = 5'h04;
    localparam logic [4:0] AMO_AND  = 5'h0C;
    localparam logic [4:0] AMO_OR   = 5'h08;
    localparam logic [4:0] AMO_MIN  = 5'h10;
    localparam logic [4:0] AMO_MAX  = 5'h14;
    localparam logic [4:0] AMO_MINU = 5'h18;
    localparam logic [4:0] AMO_MAXU = 5'h1C;

    // Vector funct6
    localparam logic [5:0] V6_ADD    = 6'h00;
    localparam logic [5:0] V6_SUB    = 6'h02;
    localparam logic [5:0] V6_AND    = 6'h09;
    localparam logic [5:0] V6_OR     = 6'h0A;
    localparam logic [5:0] V6_XOR    = 6'h0B;
    localparam logic [5:0] V6_MSEQ   = 6'h18;
    localparam logic [5:0] V6_MSLT   = 6'h1B;
    localparam logic [5:0] V6_MSLTU  = 6'h1A;
    localparam logic [5:0] V6_SLL    = 6'h25;
    localparam logic [5:0] V6_SRL    = 6'h28;
    localparam logic [5:0] V6_MV     = 6'h17;
    localparam logic [5:0] V6_REDSUM = 6'h00;
    localparam logic [5:0] V6_MAND   = 6'h19;
    localparam logic [5:0] V6_MOR    = 6'h1A;
    localparam logic [5:0] V6_MNOT   = 6'h1E;
    localparam logic [5:0] V6_WXUNARY = 6'h10;

    // System encodings
    localparam logic [31:0] ECALL_WORD   = 32'h00000073;
    localparam logic [31:0] EBREAK_WORD  = 32'h00100073;
    localparam logic [11:0] FUNCT12_MRET = 12'b001100000010;
    localparam logic [31:0] UPPER_MASK   = 32'hFFFFF000;

    // Operation numbers
    localparam logic [OpW-1:0] OP_LB = 7'd0, OP_LH = 7'd1, OP_LW = 7'd2;
    localparam logic [OpW-1:0] OP_LBU = 7'd3, OP_LHU = 7'd4;
    localparam logic [OpW-1:0] OP_SB = 7'd5, OP_SH = 7'd6, OP_SW = 7'd7;
    localparam logic [OpW-1:0] OP_BEQ = 7'd8, OP_BNE = 7'd9, OP_BLT = 7'd10;
    localparam logic [OpW-1:0] OP_BGE = 7'd11, OP_BLTU = 7'd12, OP_BGEU = 7'd13;
    localparam logic [OpW-1:0] OP_JAL = 7'd14, OP_JALR = 7'd15;
    localparam logic [OpW-1:0] OP_LUI = 7'd16, OP_AUIPC = 7'd17;
    localparam logic [OpW-1:0] OP_ADDI = 7'd18, OP_SLTI = 7'd19, OP_SLTIU = 7'd20;
    localparam logic [OpW-1:0] OP_XORI = 7'd21, OP_ORI = 7'd22, OP_ANDI = 7'd23;
    localparam logic [OpW-1:0] OP_SLLI = 7'd24, OP_SRLI = 7'd25, OP_SRAI = 7'd26;
    localparam logic [OpW-1:0] OP_ADD = 7'd27, OP_SUB = 7'd28, OP_SLL = 7'd29;
    localparam logic [OpW-1:0] OP_SLT = 7'd30, OP_SLTU = 7'd31, OP_XOR = 7'd32;
    localparam logic [OpW-1:0] OP_SRL = 7'd33, OP_SRA = 7'd34, OP_OR = 7'd35;
    localparam logic [OpW-1:0] OP_AND = 7'd36;
    localparam logic [OpW-1:0] OP_MUL = 7'd37, OP_MULH = 7'd38, OP_MULHSU = 7'd39;
    localparam logic [OpW-1:0] OP_MULHU = 7'd40, OP_DIV = 7'd41, OP_DIVU = 7'd42;
    localparam logic [OpW-1:0] OP_REM = 7'd43, OP_REMU = 7'd44;
    localparam logic [OpW-1:0] OP_LR_W = 7'd45, OP_SC_W = 7'd46;
    localparam logic [OpW-1:0] OP_AMOSWAP = 7'd47, OP_AMOADD = 7'd48;
    localparam logic [OpW-1:0] OP_AMOXOR = 7'd49, OP_AMOAND = 7'd50;
    localparam logic [OpW-1:0] OP_AMOOR = 7'd51, OP_AMOMIN = 7'd52;
    localparam logic [OpW-1:0] OP_AMOMAX = 7'd53, OP_AMOMINU = 7'd54;
    localparam logic [OpW-1:0] OP_AMOMAXU = 7'd55;
    localparam logic [OpW-1:0] OP_VSETVLI = 7'd56, OP_VSETIVLI = 7'd57;
    localparam logic [OpW-1:0] OP_VLE32 = 7'd58, OP_VSE32 = 7'd59;
    localparam logic [OpW-1:0] OP_VADD_VV = 7'd60, OP_VADD_VX = 7'd61;
    localparam logic [OpW-1:0] OP_VSUB_VV = 7'd62, OP_VSUB_VX = 7'd63;
    localparam logic [OpW-1:0] OP_VAND_VV = 7'd64, OP_VAND_VX = 7'd65;
    localparam logic [OpW-1:0] OP_VOR_VV = 7'd66, OP_VOR_VX = 7'd67;
    localparam logic [OpW-1:0] OP_VXOR_VV = 7'd68, OP_VXOR_VX = 7'd69;
    localparam logic [OpW-1:0] OP_VSLL_VX = 7'd70, OP_VSRL_VX = 7'd71;
    localparam logic [OpW-1:0] OP_VMSEQ_VV = 7'd72, OP_VMSEQ_VX = 7'd73;
    localparam logic [OpW-1:0] OP_VMSLT_VV = 7'd74, OP_VMSLTU_VV = 7'd75;
    localparam logic [OpW-1:0] OP_VMAND_MM = 7'd76, OP_VMOR_MM = 7'd77;
    localparam logic [OpW-1:0] OP_VMNOT_M = 7'd78, OP_VREDSUM_VS = 7'd79;
    localparam logic [OpW-1:0] OP_VMV_V_X = 7'd80, OP_VMV_X_S = 7'd81;
    localparam logic [OpW-1:0] OP_FENCE = 7'd82, OP_ECALL = 7'd83;
    localparam logic [OpW-1:0] OP_EBREAK = 7'd84;
    localparam logic [OpW-1:0] OP_CSRRW = 7'd85, OP_CSRRS = 7'd86, OP_CSRRC = 7'd87;
    localparam logic [OpW-1:0] OP_CSRRWI = 7'd88, OP_CSRRSI = 7'd89;
    localparam logic [OpW-1:0] OP_CSRRCI = 7'd90;
    localparam logic [OpW-1:0] OP_MRET = 7'd91;
    localparam logic [OpW-1:0] OP_INVALID = 7'd92;

    typedef struct packed {
        logic [OpW-1:0]  op;
        logic [FmtW-1:0] fmt;
        logic [RegW-1:0] rd;
        logic [RegW-1:0] rs1;
        logic [RegW-1:0] rs2;
        logic [XLen-1:0] imm;
    } dec_t;

    function automatic logic [OpW-1:0] dec_opimm(input logic [31:0] w);
        logic [2:0] f3;
        logic [6:0] f7;
        logic [OpW-1:0] op;
        f3 = w[14:12];
        f7 = w[31:25];
        unique case (f3)
            F3_0: op = OP_ADDI;
            F3_2: op = OP_SLTI;
            F3_3: op = OP_SLTIU;
            F3_4: op = OP_XORI;
            F3_6: op = OP_ORI;
            F3_7: op = OP_ANDI;
            F3_1: op = (f7 == F7_BASE) ? OP_SLLI : OP_INVALID;
            default:
            begin
                if (f7 == F7_BASE)
                    op = OP_SRLI;
                else if (f7 == F7_ALT)
                    op = OP_SRAI;
                else
                    op = OP_INVALID;
            end
        endcase
        return op;
    endfunction

    function automatic logic [OpW-1:0] dec_op(input logic [31:0] w);
        logic [2:0] f3;
        logic [6:0] f7;
        logic [OpW-1:0] op;
        f3 = w[14:12];
        f7 = w[31:25];
        op = OP_INVALID;
        if (f7 == F7_MUL)
        begin
            op = OP_MUL + OpW'(f3);
        end
        else if (f7 == F7_ALT)
        begin
            if (f3 == F3_0)
                op = OP_SUB;
            else if (f3 == F3_5)
                op = OP_SRA;
        end
        else if (f7 == F7_BASE)
        begin
            unique case (f3)
                F3_0: op = OP_ADD;
                F3_1: op = OP_SLL;
                F3_2: op = OP_SLT;
                F3_3: op = OP_SLTU;
                F3_4: op = OP_XOR;
                F3_5: op = OP_SRL;
                F3_6: op = OP_OR;
                default: op = OP_AND;
            endcase
        end
        return op;
    endfunction

    function automatic logic [OpW-1:0] dec_amo(input logic [31:0] w);
        logic [OpW-1:0] op;
        op = OP_INVALID;
        if (w[14:12] == F3_2)
        begin
            unique case (w[31:27])
                AMO_LR:   op = (w[24:20] == 5'd0) ? OP_LR_W : OP_INVALID;
                AMO_SC:   op = OP_SC_W;
                AMO_SWAP: op = OP_AMOSWAP;
                AMO_ADD:  op = OP_AMOADD;
                AMO_XOR:  op = OP_AMOXOR;
                AMO_AND:  op = OP_AMOAND;
                AMO_OR:   op = OP_AMOOR;
                AMO_MIN:  op = OP_AMOMIN;
                AMO_MAX:  op = OP_AMOMAX;
                AMO_MINU: op = OP_AMOMINU;
                AMO_MAXU: op = OP_AMOMAXU;
                default:  op = OP_INVALID;
            endcase
        end
        return op;
    endfunction

    function automatic logic [OpW-1:0] dec_vec(input logic [31:0] w);
        logic [6:0] opc;
        logic [2:0] f3;
        logic [5:0] f6;
        logic [OpW-1:0] op;
        opc = w[6:0];
        f3  = w[14:12];
        f6  = w[31:26];
        op  = OP_INVALID;
        priority if (opc == OPC_VLOAD)
        begin
            if (f3 == VF3_EW32 && w[24:20] == 5'd0)
                op = OP_VLE32;
        end
        else if (opc == OPC_VSTORE)
        begin
            if (f3 == VF3_EW32 && w[24:20] == 5'd0)
                op = OP_VSE32;
        end
        else if (f3 == VF3_CFG && !w[31])
        begin
            op = OP_VSETVLI;
        end
        else if (f3 == VF3_CFG && w[31:30] == 2'b11)
        begin
            op = OP_VSETIVLI;
        end
        else if (f3 == VF3_OPIVV)
        begin
            unique case (f6)
                V6_ADD:   op = OP_VADD_VV;
                V6_SUB:   op = OP_VSUB_VV;
                V6_AND:   op = OP_VAND_VV;
                V6_OR:    op = OP_VOR_VV;
                V6_XOR:   op = OP_VXOR_VV;
                V6_MSEQ:  op = OP_VMSEQ_VV;
                V6_MSLT:  op = OP_VMSLT_VV;
                V6_MSLTU: op = OP_VMSLTU_VV;
                default:  op = OP_INVALID;
            endcase
        end
        else if (f3 == VF3_OPIVX)
        begin
            unique case (f6)
                V6_ADD:  op = OP_VADD_VX;
                V6_SUB:  op = OP_VSUB_VX;
                V6_AND:  op = OP_VAND_VX;
                V6_OR:   op = OP_VOR_VX;
                V6_XOR:  op = OP_VXOR_VX;
                V6_SLL:  op = OP_VSLL_VX;
                V6_SRL:  op = OP_VSRL_VX;
                V6_MSEQ: op = OP_VMSEQ_VX;
                V6_MV:   op = (w[24:20] == 5'd0) ? OP_VMV_V_X : OP_INVALID;
                default: op = OP_INVALID;
            endcase
        end
        else if (f3 == VF3_OPMVV)
        begin
            unique case (f6)
                V6_REDSUM:  op = OP_VREDSUM_VS;
                V6_MAND:    op = OP_VMAND_MM;
                V6_MOR:     op = OP_VMOR_MM;
                V6_MNOT:    op = OP_VMNOT_M;
                V6_WXUNARY: op = (w[19:15] == 5'd0) ? OP_VMV_X_S : OP_INVALID;
                default:    op = OP_INVALID;
            endcase
        end
        return op;
    endfunction

    function automatic logic [OpW-1:0] dec_sys(input logic [31:0] w);
        logic [OpW-1:0] op;
        unique case (w[14:12])
            F3_0:
            begin
                if (w == ECALL_WORD)
                    op = OP_ECALL;
                else if (w == EBREAK_WORD)
                    op = OP_EBREAK;
                else if (w[31:20] == FUNCT12_MRET && w[11:7] == 5'd0 && w[19:15] == 5'd0)
                    op = OP_MRET;
                else
                    op = OP_INVALID;
            end
            F3_1:    op = OP_CSRRW;
            F3_2:    op = OP_CSRRS;
            F3_3:    op = OP_CSRRC;
            F3_5:    op = OP_CSRRWI;
            F3_6:    op = OP_CSRRSI;
            F3_7:    op = OP_CSRRCI;
            default: op = OP_INVALID;
        endcase
        return op;
    endfunction

    function automatic dec_t decode(input logic [31:0] w);
        logic [2:0]      f3;
        logic [XLen-1:0] imm_i;
        logic [XLen-1:0] imm_s;
        logic [XLen-1:0] imm_b;
        logic [XLen-1:0] imm_j;
        logic [XLen-1:0] shamt;
        dec_t            d;
        f3    = w[14:12];
        imm_i = {{20{w[31]}}, w[31:20]};
        imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
        imm_b = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
        imm_j = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
        shamt = {27'd0, w[24:20]};
        d     = '0;
        d.op  = OP_INVALID;
        d.fmt = FMT_R;
        unique case (w[6:0])
            OPC_LOAD:
            begin
                d.fmt = FMT_I; d.rd = w[11:7]; d.rs1 = w[19:15]; d.imm = imm_i;
                unique case (f3)
                    F3_0:    d.op = OP_LB;
                    F3_1:    d.op = OP_LH;
                    F3_2:    d.op = OP_LW;
                    F3_4:    d.op = OP_LBU;
                    F3_5:    d.op = OP_LHU;
                    default: d.op = OP_INVALID;
                endcase
            end
            OPC_STORE:
            begin
                d.fmt = FMT_S; d.rs1 = w[19:15]; d.rs2 = w[24:20]; d.imm = imm_s;
                unique case (f3)
                    F3_0:    d.op = OP_SB;
                    F3_1:    d.op = OP_SH;
                    F3_2:    d.op = OP_SW;
                    default: d.op = OP_INVALID;
                endcase
            end
            OPC_BRANCH:
            begin
                d.fmt = FMT_B; d.rs1 = w[19:15]; d.rs2 = w[24:20]; d.imm = imm_b;
                unique case (f3)
                    F3_0:    d.op = OP_BEQ;
                    F3_1:    d.op = OP_BNE;
                    F3_4:    d.op = OP_BLT;
                    F3_5:    d.op = OP_BGE;
                    F3_6:    d.op = OP_BLTU;
                    F3_7:    d.op = OP_BGEU;
                    default: d.op = OP_INVALID;
                endcase
            end
            OPC_OPIMM:
            begin
                d.fmt = FMT_I; d.rd = w[11:7]; d.rs1 = w[19:15];
                d.op  = dec_opimm(w);
                if (f3 == F3_5 || (f3 == F3_1 && w[31:25] == F7_BASE))
                    d.imm = shamt;
                else
                    d.imm = imm_i;
            end
            OPC_OP:
            begin
                d.rd = w[11:7]; d.rs1 = w[19:15]; d.rs2 = w[24:20];
                d.op = dec_op(w);
            end
            OPC_AMO:
            begin
                d.rd = w[11:7]; d.rs1 = w[19:15]; d.rs2 = w[24:20];
                d.op = dec_amo(w);
            end
            OPC_SYSTEM:
            begin
                d.fmt = FMT_I; d.rd = w[11:7]; d.rs1 = w[19:15];
                d.op  = dec_sys(w);
                d.imm = (f3 == F3_0) ? imm_i : {20'd0, w[31:20]};
            end
            OPC_LUI, OPC_AUIPC:
            begin
                d.fmt = FMT_U; d.rd = w[11:7]; d.imm = w & UPPER_MASK;
                d.op  = (w[6:0] == OPC_LUI) ? OP_LUI : OP_AUIPC;
            end
            OPC_JAL:
            begin
                d.fmt = FMT_J; d.rd = w[11:7]; d.imm = imm_j; d.op = OP_JAL;
            end
            OPC_JALR:
            begin
                if (f3 == F3_0)
                begin
                    d.fmt = FMT_I; d.rd = w[11:7]; d.rs1 = w[19:15];
                    d.imm = imm_i; d.op = OP_JALR;
                end
            end
            OPC_MISC_MEM:
            begin
                d.fmt = FMT_I; d.rd = w[11:7]; d.rs1 = w[19:15];
                d.imm = imm_i; d.op = OP_FENCE;
            end
            OPC_VLOAD, OPC_VSTORE, OPC_VECTOR:
            begin
                d.rd = w[11:7]; d.rs1 = w[19:15]; d.rs2 = w[24:20];
                d.op = dec_vec(w);
                if (d.op == OP_VSETVLI)
                    d.imm = {21'd0, w[30:20]};
                else if (d.op == OP_VSETIVLI)
                    d.imm = {22'd0, w[29:20]};
            end
            default:
            begin
                d = '0;
                d.op = OP_INVALID;
            end
        endcase
        return d;
    endfunction

endpackage

@@ rtl/rv32_instruction_decoder.sv @@
// RV32 instruction decoder top level; uses rvdec_pkg for codes and decode.
// Decode is one combinational pass from instr_reg/pc_reg into dec_reg/pc_out_reg.
// Throughput: one item per cycle, unless out_ready is low while a result is held.
// Reset: rst_n clears both valid flags asynchronously; payload regs are not reset.
`timescale 1ns / 1ps

module rv32_instruction_decoder
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [31:0]                        instruction,
    input  logic [31:0]                        fetch_pc,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [rvdec_pkg::OpW-1:0]          operation,
    output logic                               is_invalid,
    output logic [rvdec_pkg::FmtW-1:0]         format,
    output logic [rvdec_pkg::RegW-1:0]         dest_reg,
    output logic [rvdec_pkg::RegW-1:0]         src1_reg,
    output logic [rvdec_pkg::RegW-1:0]         src2_reg,
    output logic signed [rvdec_pkg::XLen-1:0]  immediate,
    output logic [31:0]                        pc_out
);

    logic                 in_vld_reg;
    logic                 in_vld_next;
    logic [31:0]          instr_reg;
    logic [31:0]          pc_reg;
    logic                 out_vld_reg;
    logic                 out_vld_next;
    rvdec_pkg::dec_t      dec_reg;
    rvdec_pkg::dec_t      dec_next;
    logic [31:0]          pc_out_reg;
    logic                 out_load;
    logic                 in_load;

    // advance the result stage when it is empty or being drained
    assign out_load = in_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready = !in_vld_reg || !out_vld_reg || out_ready;
    assign in_load  = in_valid && in_ready;

    assign in_vld_next  = in_load || (in_vld_reg && !out_load);
    assign out_vld_next = out_load || (out_vld_reg && !out_ready);
    assign dec_next     = rvdec_pkg::decode(instr_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
        begin
            instr_reg <= instruction;
            pc_reg    <= fetch_pc;
        end
        if (out_load)
        begin
            dec_reg    <= dec_next;
            pc_out_reg <= pc_reg;
        end
    end

    assign out_valid  = out_vld_reg;
    assign operation  = dec_reg.op;
    assign is_invalid = (dec_reg.op == rvdec_pkg::OP_INVALID);
    assign format     = dec_reg.fmt;
    assign dest_reg   = dec_reg.rd;
    assign src1_reg   = dec_reg.rs1;
    assign src2_reg   = dec_reg.rs2;
    assign immediate  = $signed(dec_reg.imm);
    assign pc_out     = pc_out_reg;

endmodule
